// File: rtl/format_literal_converter_scan_core_assert.svh
// Assertion macros for the format literal converter scan core.
// Both expect a signal named clk in the scope of use; FLCS_ASSERT also expects rst_n.
`ifndef FORMAT_LITERAL_CONVERTER_SCAN_CORE_ASSERT_SVH
`define FORMAT_LITERAL_CONVERTER_SCAN_CORE_ASSERT_SVH

// Checked only while out of reset.
`define FLCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define FLCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/flcs_pkg.sv
// ----------------------------------------------------------------------------
// flcs_pkg
// Shared types, character codes and conversion tables of the format
// literal converter scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package flcs_pkg;

  // Default depth of the queue between the front and back parts
  localparam int QUEUE_DEPTH = 2;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_LBR    = 8'h5B;
  localparam logic [7:0] CH_RBR    = 8'h5D;

  // Set by any flag, width or precision character
  localparam logic [31:0] OPT_BIT = 32'h4000_0000;

  typedef struct packed {
    logic       start_req;
    logic       scanf_table;
    logic [7:0] text_char;
    logic       end_of_text;
  } flcs_in_t;

  typedef struct packed {
    logic [31:0] converter_mask;
    logic        done_res;
  } flcs_out_t;

  // One classified character as the back part consumes it
  typedef struct packed {
    logic        start;
    logic        eot;
    logic        is_nul;
    logic        is_quote;
    logic        is_bslash;
    logic        is_pct;
    logic        is_flag;
    logic        is_digit;
    logic        is_l;
    logic        is_h;
    logic        is_zjt;
    logic        is_rbr;
    logic        is_ws;
    logic        is_set;
    logic [31:0] plain;
    logic [31:0] longv;
  } flcs_cls_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic valid;
    logic full;
  } flcs_qstat_t;

  typedef struct packed {
    logic [31:0] plain;
    logic [31:0] longv;
  } flcs_bits_t;

  // Look up converter bits of a conversion character; unknown gives zero
  function automatic flcs_bits_t flcs_lookup(input logic [7:0] c, input logic scan);
    flcs_bits_t b;
    b = '0;
    case (c)
      "d": b = '{32'h0000_0001, 32'h0000_1000};
      "u": b = '{32'h0000_0002, 32'h0000_2000};
      "x": b = '{32'h0000_0004, 32'h0000_4000};
      "X": b = '{32'h0000_0008, 32'h0000_8000};
      "o": b = '{32'h0000_0010, 32'h0001_0000};
      "n": b = '{32'h0000_0020, 32'h0002_0000};
      "i": b = '{32'h0000_0040, 32'h0004_0000};
      "p": b = '{32'h0000_0080, 32'h0008_0000};
      "B": b = '{32'h0000_0100, 32'h0010_0000};
      "s": b = '{32'h0000_0200, 32'h0000_0000};
      "S": if (!scan) b = '{32'h0200_0200, 32'h0000_0000};
      "c": b = '{32'h0000_0400, 32'h0000_0000};
      "I": b = '{32'h0000_0800, 32'h0000_0000};
      "[": if (scan) b = '{32'h0020_0000, 32'h0020_0000};
      "a": b = '{32'h0040_0000, 32'h0040_0000};
      "A": b = '{32'h0080_0000, 32'h0080_0000};
      "e": b = '{32'h0100_0000, 32'h0100_0000};
      "E": b = '{32'h0200_0000, 32'h0200_0000};
      "f": b = '{32'h0400_0000, 32'h0400_0000};
      "F": b = '{32'h0800_0000, 32'h0800_0000};
      "g": b = '{32'h1000_0000, 32'h1000_0000};
      "G": b = '{32'h2000_0000, 32'h2000_0000};
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: rtl/flcs_front.sv
// ----------------------------------------------------------------------------
// flcs_front
// Accepts input items, samples the table select and classifies each
// character into flags and converter bits for the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module flcs_front (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  flcs_pkg::flcs_in_t     in_data,
  input  flcs_pkg::flcs_qstat_t  q_stat,
  output logic                   push,
  output flcs_pkg::flcs_cls_t    push_data
);
  import flcs_pkg::*;

  logic       table_sel_r;
  logic       table_sel_nxt;
  logic       sel;
  logic [7:0] c;
  flcs_bits_t bits;

  // Accept whenever the queue has room
  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  // Table select is sampled with a start item and used from that item on
  assign sel           = in_data.start_req ? in_data.scanf_table : table_sel_r;
  assign table_sel_nxt = (push && in_data.start_req) ? in_data.scanf_table : table_sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_sel_r <= 1'b0;
    end else begin
      table_sel_r <= table_sel_nxt;
    end
  end

  // Classify the character
  assign c    = in_data.text_char;
  assign bits = flcs_lookup(c, sel);

  always_comb begin
    push_data           = '0;
    push_data.start     = in_data.start_req;
    push_data.eot       = in_data.end_of_text;
    push_data.is_nul    = (c == CH_NUL);
    push_data.is_quote  = (c == CH_QUOTE);
    push_data.is_bslash = (c == CH_BSLASH);
    push_data.is_pct    = (c == CH_PCT);
    push_data.is_flag   = (c == "-") || (c == "+") || (c == " ") || (c == "#") || (c == "0");
    push_data.is_digit  = ((c >= "0") && (c <= "9")) || (c == ".") || (c == "*");
    push_data.is_l      = (c == "l");
    push_data.is_h      = (c == "h");
    push_data.is_zjt    = (c == "z") || (c == "j") || (c == "t");
    push_data.is_rbr    = (c == CH_RBR);
    push_data.is_ws     = (c == " ") || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) ||
                          (c == 8'h0C) || (c == 8'h0D);
    push_data.is_set    = sel && (c == CH_LBR);
    push_data.plain     = bits.plain;
    push_data.longv     = bits.longv;
  end

endmodule

`default_nettype wire

// File: rtl/flcs_queue.sv
// ----------------------------------------------------------------------------
// flcs_queue
// Short queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module flcs_queue #(
  parameter int DEPTH = flcs_pkg::QUEUE_DEPTH
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    push,
  input  flcs_pkg::flcs_cls_t    push_data,
  input  wire                    pop,
  output flcs_pkg::flcs_cls_t    pop_data,
  output flcs_pkg::flcs_qstat_t  q_stat
);
  import flcs_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  flcs_cls_t       slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign q_stat.valid = (cnt_r != '0);
  assign q_stat.full  = (cnt_r == CW'(DEPTH));
  assign pop_data     = slot_r[rd_ptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold payload in the slots
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/flcs_back.sv
// ----------------------------------------------------------------------------
// flcs_back
// Scan state machine: consumes one classified item per cycle when the result
// register is free, updates the converter mask and loads the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module flcs_back (
  input  wire                    clk,
  input  wire                    rst_n,
  input  flcs_pkg::flcs_qstat_t  q_stat,
  input  flcs_pkg::flcs_cls_t    item,
  output logic                   pop,
  output logic                   out_valid,
  input  wire                    out_ready,
  output flcs_pkg::flcs_out_t    out_data
);
  import flcs_pkg::*;

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_OPEN  = 4'd1;
  localparam logic [3:0] PH_LIT   = 4'd2;
  localparam logic [3:0] PH_ESC   = 4'd3;
  localparam logic [3:0] PH_PCT   = 4'd4;
  localparam logic [3:0] PH_FLAG  = 4'd5;
  localparam logic [3:0] PH_WIDTH = 4'd6;
  localparam logic [3:0] PH_LEN_L = 4'd7;
  localparam logic [3:0] PH_LEN_H = 4'd8;
  localparam logic [3:0] PH_CONV  = 4'd9;
  localparam logic [3:0] PH_SET   = 4'd10;
  localparam logic [3:0] PH_AFTER = 4'd11;

  logic [3:0]  phase_r, phase_nxt;
  logic [31:0] mask_r, mask_nxt;
  logic        long_r, long_nxt;
  logic        out_valid_r;
  flcs_out_t   out_data_r;

  logic [3:0]  ph;
  logic        in_flag_ph, in_spec_ph;

  // Take an item when the result register is free or being drained
  assign pop       = q_stat.valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_flag_ph = (ph == PH_PCT) || (ph == PH_FLAG);
  assign in_spec_ph = in_flag_ph || (ph == PH_WIDTH);

  // Next scan state for the item at the queue head
  always_comb begin
    ph        = item.start ? PH_OPEN : phase_r;
    mask_nxt  = item.start ? '0 : mask_r;
    long_nxt  = item.start ? 1'b0 : long_r;
    phase_nxt = ph;
    if (ph != PH_IDLE) begin
      if (item.is_nul) begin
        phase_nxt = PH_IDLE;
      end else begin
        unique case (ph)
          PH_OPEN: begin
            phase_nxt = item.is_quote ? PH_LIT : PH_IDLE;
          end
          PH_AFTER: begin
            if (item.is_quote) begin
              phase_nxt = PH_LIT;
            end else if (!item.is_ws) begin
              phase_nxt = PH_IDLE;
            end
          end
          PH_LIT: begin
            if (item.is_quote) begin
              phase_nxt = PH_AFTER;
            end else if (item.is_bslash) begin
              phase_nxt = PH_ESC;
            end else if (item.is_pct) begin
              long_nxt  = 1'b0;
              phase_nxt = PH_PCT;
            end
          end
          PH_ESC: begin
            phase_nxt = PH_LIT;
          end
          PH_SET: begin
            if (item.is_rbr) begin
              phase_nxt = PH_LIT;
            end
          end
          PH_PCT, PH_FLAG, PH_WIDTH, PH_LEN_L, PH_LEN_H, PH_CONV: begin
            if ((ph == PH_PCT) && item.is_pct) begin
              phase_nxt = PH_LIT;
            end else if (in_flag_ph && item.is_flag) begin
              mask_nxt  = mask_nxt | OPT_BIT;
              phase_nxt = PH_FLAG;
            end else if (in_spec_ph && item.is_digit) begin
              mask_nxt  = mask_nxt | OPT_BIT;
              phase_nxt = PH_WIDTH;
            end else if (in_spec_ph && item.is_l) begin
              long_nxt  = 1'b1;
              phase_nxt = PH_LEN_L;
            end else if (in_spec_ph && item.is_h) begin
              phase_nxt = PH_LEN_H;
            end else if (in_spec_ph && item.is_zjt) begin
              phase_nxt = PH_CONV;
            end else if ((ph == PH_LEN_L) && item.is_l) begin
              phase_nxt = PH_CONV;
            end else if ((ph == PH_LEN_H) && item.is_h) begin
              phase_nxt = PH_CONV;
            end else if (item.is_quote) begin
              // quote in place of a conversion closes the literal
              phase_nxt = PH_AFTER;
            end else begin
              mask_nxt  = mask_nxt | (long_nxt ? item.longv : item.plain);
              phase_nxt = item.is_set ? PH_SET : PH_LIT;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
      if (item.eot) begin
        phase_nxt = PH_IDLE;
      end
    end
  end

  // Advance scan state and result register on each taken item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      mask_r      <= '0;
      long_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r     <= phase_nxt;
        mask_r      <= mask_nxt;
        long_r      <= long_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r.converter_mask <= mask_nxt;
      out_data_r.done_res       <= (phase_nxt == PH_IDLE);
    end
  end

endmodule

`default_nettype wire

// File: rtl/format_literal_converter_scan_core.sv
// ----------------------------------------------------------------------------
// format_literal_converter_scan_core
// Scans printf/scanf format literals one character per item and reports
// the running converter mask and a done flag for every character.
//
//   Channel  Ports                          Payload
//   input    in_valid / in_ready / in_data  flcs_in_t: start, table, char, eot
//   result   out_valid/ out_ready/ out_data flcs_out_t: mask, done
//
// One item per cycle sustained while results are taken; an item is written
// into a queue slot when it is accepted, and its result register loads when
// the back part takes it from the queue.
// The scan state machine in the back part updates once per item.
// Reset (rst_n low, synchronous) empties the queue, clears the mask and
// leaves the scan idle; no clearing pass is needed.
// A stalled result holds in its register while the queue of QUEUE_DEPTH
// items keeps taking input; in_ready drops only when the queue is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module format_literal_converter_scan_core #(
  parameter int QUEUE_DEPTH = flcs_pkg::QUEUE_DEPTH
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  flcs_pkg::flcs_in_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output flcs_pkg::flcs_out_t  out_data
);
  import flcs_pkg::*;

  flcs_qstat_t q_stat;
  flcs_cls_t   push_data;
  flcs_cls_t   pop_data;
  logic        push;
  logic        pop;

  flcs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  flcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  flcs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .item      (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: rtl/flcs_checker.sv
// ----------------------------------------------------------------------------
// flcs_checker
// Port-level checks on the scanner: item accounting, result hold and
// reset behavior.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "format_literal_converter_scan_core_assert.svh"

module flcs_checker #(
  parameter int QUEUE_DEPTH = flcs_pkg::QUEUE_DEPTH
) (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_ready,
  input wire                  out_valid,
  input wire                  out_ready,
  input flcs_pkg::flcs_out_t  out_data
);
  import flcs_pkg::*;

  localparam int MAX_FLIGHT = QUEUE_DEPTH + 1;
  localparam int FW         = $clog2(MAX_FLIGHT + 2);

  logic          in_acc, out_acc;
  logic [FW-1:0] flight_r, flight_nxt;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Track items accepted but not yet delivered
  always_comb begin
    flight_nxt = flight_r;
    if (in_acc && !out_acc) begin
      flight_nxt = flight_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      flight_nxt = flight_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flight_r <= '0;
    end else begin
      flight_r <= flight_nxt;
    end
  end

  `FLCS_ASSERT(a_no_invented, out_valid |-> (flight_r != '0), "result without a pending item")
  `FLCS_ASSERT(a_flight_bound, flight_r <= FW'(MAX_FLIGHT), "more items in flight than storage")
  `FLCS_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)), "stalled result changed")
  `FLCS_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind format_literal_converter_scan_core flcs_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_flcs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
